// ===== hdl/nmea_sentence_framer_checker_unit_assert.svh =====
// Assertion macros used by the framer queue module.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_UNIT_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define NSFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define NSFC_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/nsfc_pkg.sv =====
`timescale 1ns / 1ps
package nsfc_pkg;

	localparam int CNT_W_DEF = 8;
	localparam int TAIL_N = 4;
	localparam int XOR_FROM = 5;
	localparam int MIN_FRAME = 8;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [7:0] START_RST = 8'h24;
	localparam logic [7:0] MAXLEN_RST = 8'd199;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam logic REG_START = 1'b0;
	localparam logic REG_MAXLEN = 1'b1;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SHORT,
		ST_BADHEX,
		ST_MISMATCH
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] idx;
		logic       valid;
		logic       start;
		logic       fin;
		logic       aband;
		logic       too_short;
		logic [7:0] sum;
		logic [7:0] t3;
		logic [7:0] t2;
		logic [7:0] t1;
	} res_t;

	// {bad, nibble}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		d = c - 8'd55;
		if (c inside {[8'h30:8'h39]}) begin
			return {1'b0, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

endpackage

// ===== hdl/nsfc_if.sv =====
`timescale 1ns / 1ps
interface nsfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nsfc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [7:0] byte_index;
	logic       byte_valid;
	logic       frame_start;
	logic       frame_end;
	logic       frame_abandoned;
	logic [1:0] status;
	logic [7:0] computed_checksum;

	modport source (output valid, output out_byte, output byte_index, output byte_valid,
		output frame_start, output frame_end, output frame_abandoned, output status,
		output computed_checksum, input ready);
	modport sink (input valid, input out_byte, input byte_index, input byte_valid,
		input frame_start, input frame_end, input frame_abandoned, input status,
		input computed_checksum, output ready);
endinterface

// ===== hdl/nsfc_front.sv =====
`timescale 1ns / 1ps
module nsfc_front import nsfc_pkg::*; #(
	parameter int COUNT_WIDTH = CNT_W_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] start_char,
	input  logic [7:0] max_len,
	nsfc_rx_if.sink    rx,
	input  logic       q_full,
	output logic       push,
	output res_t       push_data
);

	localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic                   in_frame_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   prev_cr_q;
	logic [7:0]             xor_q;
	logic [7:0]             tail_q [TAIL_N];

	logic                   n_in;
	logic [COUNT_WIDTH-1:0] n_cnt;
	logic                   n_prev;
	logic [7:0]             n_xor;
	logic [7:0]             n_tail [TAIL_N];

	logic                   accept;
	logic [7:0]             b;
	logic [CMP_W-1:0]       cnt_ext;
	logic                   ab;
	logic                   live;
	logic                   is_fin;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [7:0]             xor_upd;
	res_t                   res;

	assign rx.ready = !q_full;
	assign accept = rx.valid && rx.ready;
	assign b = rx.rx_byte;

	assign cnt_ext = CMP_W'(cnt_q);
	assign ab = in_frame_q && ((cnt_ext > CMP_W'(max_len)) || (cnt_q == CNT_MAX));
	assign live = in_frame_q && !ab;
	assign is_fin = live && (b == CH_LF) && prev_cr_q;
	assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign xor_upd = (cnt_q >= COUNT_WIDTH'(XOR_FROM)) ? (xor_q ^ tail_q[TAIL_N-1]) : xor_q;

	always_comb begin
		n_in = in_frame_q;
		n_cnt = cnt_q;
		n_prev = prev_cr_q;
		n_xor = xor_q;
		for (int i = 0; i < TAIL_N; i++) begin
			n_tail[i] = tail_q[i];
		end
		res = '0;
		res.aband = ab;
		if (b == start_char) begin
			res.valid = 1'b1;
			res.start = 1'b1;
			res.data = b;
			n_in = 1'b1;
			n_cnt = COUNT_WIDTH'(1);
			n_prev = 1'b0;
			n_xor = '0;
			n_tail[0] = b;
			for (int i = 1; i < TAIL_N; i++) begin
				n_tail[i] = '0;
			end
		end else if (!live) begin
			n_in = 1'b0;
			n_prev = 1'b0;
			if (ab) begin
				n_cnt = '0;
			end
		end else begin
			res.valid = 1'b1;
			res.data = b;
			res.idx = cnt_ext[7:0];
			n_xor = xor_upd;
			n_tail[0] = b;
			for (int i = 1; i < TAIL_N; i++) begin
				n_tail[i] = tail_q[i-1];
			end
			if (is_fin) begin
				res.fin = 1'b1;
				res.sum = xor_q;
				res.too_short = cnt_ext < CMP_W'(MIN_FRAME - 1);
				res.t3 = tail_q[3];
				res.t2 = tail_q[2];
				res.t1 = tail_q[1];
				n_in = 1'b0;
				n_cnt = '0;
				n_prev = 1'b0;
			end else begin
				n_cnt = cnt_inc;
				n_prev = (b == CH_CR);
			end
		end
	end

	assign push = accept && (res.valid || res.aband);
	assign push_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q <= '0;
			prev_cr_q <= 1'b0;
			xor_q <= '0;
			for (int i = 0; i < TAIL_N; i++) begin
				tail_q[i] <= '0;
			end
		end else if (accept) begin
			in_frame_q <= n_in;
			cnt_q <= n_cnt;
			prev_cr_q <= n_prev;
			xor_q <= n_xor;
			for (int i = 0; i < TAIL_N; i++) begin
				tail_q[i] <= n_tail[i];
			end
		end
	end

endmodule

// ===== hdl/nsfc_queue.sv =====
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_unit_assert.svh"
module nsfc_queue import nsfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_data,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output res_t q_data
);

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	`NSFC_ASSERT(a_no_push_full, push |-> !full, "request pushed into full queue")
	`NSFC_ASSERT(a_no_pop_empty, pop |-> q_valid, "request popped from empty queue")
	`NSFC_ASSERT(a_count_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count lost a push")
	`NSFC_CHECK(a_reset_empty, !arst_n |-> !q_valid, "queue not empty in reset")

endmodule

// ===== hdl/nsfc_back.sv =====
`timescale 1ns / 1ps
module nsfc_back import nsfc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  res_t     q_data,
	output logic     pop,
	nsfc_res_if.source res
);

	logic       out_valid_q;
	res_t       out_q;
	status_t    status_q;
	status_t    st;
	logic [4:0] hi;
	logic [4:0] lo;

	assign hi = hex_value(q_data.t2);
	assign lo = hex_value(q_data.t1);

	always_comb begin
		if (!q_data.fin) begin
			st = ST_OK;
		end else if (q_data.too_short || (q_data.t3 != CH_STAR)) begin
			st = ST_SHORT;
		end else if (hi[4] || lo[4]) begin
			st = ST_BADHEX;
		end else if ({hi[3:0], lo[3:0]} != q_data.sum) begin
			st = ST_MISMATCH;
		end else begin
			st = ST_OK;
		end
	end

	assign pop = q_valid && (!out_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= q_data;
			status_q <= st;
		end
	end

	assign res.valid = out_valid_q;
	assign res.out_byte = out_q.data;
	assign res.byte_index = out_q.idx;
	assign res.byte_valid = out_q.valid;
	assign res.frame_start = out_q.start;
	assign res.frame_end = out_q.fin;
	assign res.frame_abandoned = out_q.aband;
	assign res.status = status_q;
	assign res.computed_checksum = out_q.sum;

endmodule

// ===== hdl/nmea_sentence_framer_checker_unit.sv =====
// An accepted byte is written into the queue, then into the result register, which drives the result.
// Throughput: one byte per cycle while the queue is not full, set by the framing update in the front.
// A two-entry queue sits between front and result register; each side stalls alone.
// Reset (arst_n low, asynchronous): frame closed, counters and checksum cleared,
// queue and result register empty, start_char back to '$' and max_len to 199.
`timescale 1ns / 1ps
module nmea_sentence_framer_checker_unit import nsfc_pkg::*; #(
	parameter int COUNT_WIDTH = CNT_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	nsfc_rx_if.sink           rx,
	nsfc_res_if.source        res
);

	logic [7:0] start_q;
	logic [7:0] maxlen_q;
	logic       wr_en;
	logic       push;
	res_t       push_data;
	logic       full;
	logic       pop;
	logic       q_valid;
	res_t       q_data;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RST;
			maxlen_q <= MAXLEN_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_START: start_q <= pwdata[7:0];
				REG_MAXLEN: maxlen_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START: prdata = {(DATA_W - 8)'(0), start_q};
			REG_MAXLEN: prdata = {(DATA_W - 8)'(0), maxlen_q};
			default: prdata = '0;
		endcase
	end

	nsfc_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start_char(start_q),
		.max_len(maxlen_q),
		.rx(rx),
		.q_full(full),
		.push(push),
		.push_data(push_data)
	);

	nsfc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.q_valid(q_valid),
		.q_data(q_data)
	);

	nsfc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(pop),
		.res(res)
	);

endmodule
